### rtl/bdq_pkg.sv
// Package for the bounded deque: ring size, derived widths, operation and
// status codes, controller states, command/status structs and ring helpers.
// No dependencies.
package bdq_pkg;

    localparam int DEPTH = 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 4;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int WORD_W = 32;
    localparam int KIND_W = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_POP_BACK   = 3'd2,
        KIND_POP_FRONT  = 3'd3,
        KIND_CLEAR      = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic load_out;
    } dq_cmd_t;

    typedef struct packed {
        logic out_free;
    } dq_stat_t;

    // Ring position base + off, where the sum stays below twice the ring size.
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH))
        begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return IDX_W'(sum);
    endfunction

    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
        logic [IDX_W-1:0] res;
        if (base == '0)
        begin
            res = IDX_W'(DEPTH - 1);
        end
        else
        begin
            res = base - IDX_W'(1);
        end
        return res;
    endfunction

endpackage

### rtl/bounded_deque.sv
// Top level of the bounded deque: joins the controller and the datapath.
// Depends on bdq_pkg, bdq_ctrl, bdq_datapath and bdq_ram.
//
//  Channel   Handshake             Payload
//  -------   -------------------   ------------------------------------------
//  input     in_valid / in_stall   kind, value
//  output    out_valid / out_stall front_value, back_value, count, is_empty,
//                                  is_full, status
//  config    cfg_wr_en             cfg_wr_data (capacity)
//
// Each transaction passes through accept, index update and ring write, ring
// read and result load. The ring memory has a registered read, which can only
// start once the write of the same transaction is done. Reset clears the
// indexes, the count and the output valid; capacity returns to 8. The ring
// itself is not cleared, and only written entries are read. A held output
// stalls the result load; the next input waits until it lands.
module bounded_deque
    import bdq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CAP_W-1:0]          cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [KIND_W-1:0]         kind,
    input  logic signed [WORD_W-1:0]  value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [WORD_W-1:0]  front_value,
    output logic signed [WORD_W-1:0]  back_value,
    output logic [COUNT_W-1:0]        count,
    output logic                      is_empty,
    output logic                      is_full,
    output logic [STATUS_W-1:0]       status
);

    dq_cmd_t  cmd;
    dq_stat_t stat;

    bdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    bdq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .kind        (kind),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .front_value (front_value),
        .back_value  (back_value),
        .count       (count),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .status      (status)
    );

endmodule

### rtl/bdq_ram.sv
// Generic RAM: one write port and two read ports with registered read data.
// No dependencies.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int WORDS = 8
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] rd_addr_a,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]                        rd_data_a,
    output logic [WIDTH-1:0]                        rd_data_b
);

    logic [WIDTH-1:0] mem_reg [WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_a <= mem_reg[rd_addr_a];
        rd_data_b <= mem_reg[rd_addr_b];
    end

endmodule

### rtl/bdq_ctrl.sv
// Controller for the bounded deque: sequences one transaction through
// update, memory read and result load. Depends on bdq_pkg.
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dq_stat_t stat,
    output dq_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall      = 1'b1;
        cmd.load_item = 1'b0;
        cmd.exec      = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.load_item = in_valid;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_READ:
            begin
                cmd.exec = 1'b0;
            end
            S_RESULT:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

### rtl/bdq_datapath.sv
// Datapath for the bounded deque: capacity register, ring indexes, the ring
// memory and the output register. Depends on bdq_pkg and bdq_ram.
module bdq_datapath
    import bdq_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dq_cmd_t                    cmd,
    output dq_stat_t                   stat,
    input  logic                       cfg_wr_en,
    input  logic [CAP_W-1:0]           cfg_wr_data,
    input  logic [KIND_W-1:0]          kind,
    input  logic signed [WORD_W-1:0]   value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [WORD_W-1:0]   front_value,
    output logic signed [WORD_W-1:0]   back_value,
    output logic [COUNT_W-1:0]         count,
    output logic                       is_empty,
    output logic                       is_full,
    output logic [STATUS_W-1:0]        status
);

    logic [CAP_W-1:0]    cap_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [WORD_W-1:0]   value_reg;
    logic [IDX_W-1:0]    front_reg;
    logic [IDX_W-1:0]    front_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    status_t             status_reg;
    status_t             status_next;
    logic [CMP_W-1:0]    eff_cap;
    logic                full;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W-1:0]    back_idx;
    logic [WORD_W-1:0]   rd_front;
    logic [WORD_W-1:0]   rd_back;
    logic                out_valid_reg;
    logic [WORD_W-1:0]   front_value_reg;
    logic [WORD_W-1:0]   back_value_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                is_empty_reg;
    logic                is_full_reg;
    logic [STATUS_W-1:0] status_out_reg;

    assign eff_cap = (CMP_W'(cap_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_reg);
    assign full    = CMP_W'(cnt_reg) >= eff_cap;

    // Back entry sits count - 1 places after the front; meaningless when empty.
    assign back_idx = ring_add(front_reg, cnt_reg - CNT_W'(1));

    always_comb
    begin
        front_next  = front_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = front_reg;
        if (cmd.exec)
        begin
            status_next = ST_DONE;
            case (kind_reg)
                KIND_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = ring_add(front_reg, cnt_reg);
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                KIND_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        front_next = ring_dec(front_reg);
                        wr_en      = 1'b1;
                        wr_addr    = front_next;
                        cnt_next   = cnt_reg + CNT_W'(1);
                    end
                end
                KIND_POP_BACK:
                begin
                    if (cnt_reg == '0)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
                KIND_POP_FRONT:
                begin
                    if (cnt_reg == '0)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        front_next = ring_add(front_reg, CNT_W'(1));
                        cnt_next   = cnt_reg - CNT_W'(1);
                    end
                end
                KIND_CLEAR:
                begin
                    front_next = '0;
                    cnt_next   = '0;
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            front_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            front_reg <= front_next;
            cnt_reg   <= cnt_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (cmd.load_item)
        begin
            kind_reg  <= kind;
            value_reg <= value;
        end
        if (cmd.load_out)
        begin
            if (cnt_reg == '0)
            begin
                front_value_reg <= '1;
                back_value_reg  <= '1;
            end
            else
            begin
                front_value_reg <= rd_front;
                back_value_reg  <= rd_back;
            end
            count_reg      <= COUNT_W'(cnt_reg);
            is_empty_reg   <= (cnt_reg == '0);
            is_full_reg    <= full;
            status_out_reg <= status_reg;
        end
    end

    bdq_ram #(
        .WIDTH (WORD_W),
        .WORDS (DEPTH)
    ) u_ring (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (value_reg),
        .rd_addr_a (front_reg),
        .rd_addr_b (back_idx),
        .rd_data_a (rd_front),
        .rd_data_b (rd_back)
    );

    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign front_value = front_value_reg;
    assign back_value  = back_value_reg;
    assign count       = count_reg;
    assign is_empty    = is_empty_reg;
    assign is_full     = is_full_reg;
    assign status      = status_out_reg;

endmodule
